[rtl/crcfpb_pkg.sv]
// crcfpb_pkg: shared types, constants and the crc byte update for the frame builder
// no dependencies

package crcfpb_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;
    localparam logic [7:0]  SYNC_A   = 8'hAA;
    localparam logic [7:0]  SYNC_B   = 8'h55;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        start;
        logic        has_payload;
        logic        close;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic [31:0] timestamp;
    } t_cmd;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[rtl/crcfpb_front.sv]
// crcfpb_front: accepts input beats, tracks frame state and classifies each beat
// depends on crcfpb_pkg

module crcfpb_front import crcfpb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_payload_byte,
    input  logic [15:0] i_frame_length,
    input  logic [31:0] i_timestamp,
    input  logic        i_push_ready,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic        r_open;
    logic [15:0] r_rem;
    logic        n_open;
    logic [15:0] n_rem;
    logic [15:0] rem_dec;

    assign o_push = i_valid && i_push_ready;

    always_comb begin
        o_cmd.payload_byte = i_payload_byte;
        o_cmd.frame_length = i_frame_length;
        o_cmd.timestamp    = i_timestamp;
        n_open             = r_open;
        n_rem              = r_rem;
        rem_dec            = 16'h0000;
        if (!r_open) begin
            o_cmd.start = 1'b1;
            if (i_frame_length == 16'h0000) begin
                o_cmd.has_payload = 1'b0;
                o_cmd.close       = 1'b1;
            end else begin
                rem_dec           = i_frame_length - 16'd1;
                o_cmd.has_payload = 1'b1;
                o_cmd.close       = (rem_dec == 16'h0000);
                n_open            = (rem_dec != 16'h0000);
                n_rem             = rem_dec;
            end
        end else begin
            rem_dec           = (r_rem != 16'h0000) ? (r_rem - 16'd1) : r_rem;
            o_cmd.start       = 1'b0;
            o_cmd.has_payload = 1'b1;
            o_cmd.close       = (rem_dec == 16'h0000);
            n_open            = (rem_dec != 16'h0000);
            n_rem             = rem_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_rem  <= 16'h0000;
        end else if (o_push) begin
            r_open <= n_open;
            r_rem  <= n_rem;
        end
    end

endmodule

[rtl/crcfpb_queue.sv]
// crcfpb_queue: two-entry command queue between the front and back sections
// depends on crcfpb_pkg

module crcfpb_queue import crcfpb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

[rtl/crcfpb_back.sv]
// crcfpb_back: byte sequencer, crc update and output register
// depends on crcfpb_pkg

module crcfpb_back import crcfpb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_last,
    output logic       o_eof
);

    localparam logic [3:0] PH_SYNC0  = 4'd0;
    localparam logic [3:0] PH_SYNC1  = 4'd1;
    localparam logic [3:0] PH_SYNC2  = 4'd2;
    localparam logic [3:0] PH_SYNC3  = 4'd3;
    localparam logic [3:0] PH_LEN0   = 4'd4;
    localparam logic [3:0] PH_LEN1   = 4'd5;
    localparam logic [3:0] PH_TS0    = 4'd6;
    localparam logic [3:0] PH_TS1    = 4'd7;
    localparam logic [3:0] PH_TS2    = 4'd8;
    localparam logic [3:0] PH_TS3    = 4'd9;
    localparam logic [3:0] PH_DATA   = 4'd10;
    localparam logic [3:0] PH_CRC_LO = 4'd11;
    localparam logic [3:0] PH_CRC_HI = 4'd12;

    logic        r_mid;
    logic [3:0]  r_phase;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_out_eof;

    logic [3:0]  phase;
    logic [3:0]  n_phase;
    logic        done;
    logic [7:0]  byte_sel;
    logic        emit;

    assign emit  = i_cmd_valid && (!r_out_valid || i_ready);
    assign phase = r_mid ? r_phase : (i_cmd.start ? PH_SYNC0 : PH_DATA);
    assign o_pop = emit && done;

    always_comb begin
        n_phase  = phase + 4'd1;
        done     = 1'b0;
        byte_sel = 8'h00;
        case (phase)
            PH_SYNC0, PH_SYNC2: byte_sel = SYNC_A;
            PH_SYNC1, PH_SYNC3: byte_sel = SYNC_B;
            PH_LEN0:   byte_sel = i_cmd.frame_length[7:0];
            PH_LEN1:   byte_sel = i_cmd.frame_length[15:8];
            PH_TS0:    byte_sel = i_cmd.timestamp[7:0];
            PH_TS1:    byte_sel = i_cmd.timestamp[15:8];
            PH_TS2:    byte_sel = i_cmd.timestamp[23:16];
            PH_TS3: begin
                byte_sel = i_cmd.timestamp[31:24];
                n_phase  = i_cmd.has_payload ? PH_DATA : PH_CRC_LO;
            end
            PH_DATA: begin
                byte_sel = i_cmd.payload_byte;
                done     = !i_cmd.close;
            end
            PH_CRC_LO: byte_sel = r_crc[7:0];
            PH_CRC_HI: begin
                byte_sel = r_crc[15:8];
                done     = 1'b1;
            end
            default: done = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid       <= 1'b0;
            r_phase     <= PH_SYNC0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_mid   <= !done;
                r_phase <= n_phase;
                if (phase == PH_CRC_HI) begin
                    r_crc <= CRC_INIT;
                end else if (phase != PH_CRC_LO) begin
                    r_crc <= crc_feed(r_crc, byte_sel);
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= byte_sel;
            r_out_last <= done;
            r_out_eof  <= (phase == PH_CRC_HI);
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_last  = r_out_last;
    assign o_eof   = r_out_eof;

`ifndef ASSERT_OFF
    a_eof_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_eof |-> r_out_last)
        else $error("frame end without run end");
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && (phase == PH_CRC_HI) |=> (r_crc == CRC_INIT) && !r_mid)
        else $error("crc not restored after frame end");
    a_mid_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid |-> i_cmd_valid)
        else $error("sequencer mid command with empty queue");
`endif

endmodule

[rtl/crc16_framed_packet_builder.sv]
// crc16_framed_packet_builder: top level, front classifier, command queue, byte sequencer
// depends on crcfpb_pkg, crcfpb_front, crcfpb_queue, crcfpb_back
// path: with an idle sequencer an input beat is written into the command queue, and its first
// output byte is then registered in the output register; throughput: one input beat per cycle
// inside a frame while the output is not stalled; a frame-starting beat occupies the sequencer (header, payload, crc)
// reset: synchronous active-low i_rst_n clears the queue, frame state and output valid

module crc16_framed_packet_builder import crcfpb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // payload_byte[7:0], frame_length[23:8], timestamp[55:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // frame_byte[7:0]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // last_of_run[0]
);

    logic push;
    logic push_ready;
    t_cmd front_cmd;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    assign s_axis_tready = push_ready;

    crcfpb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .i_payload_byte (s_axis_tdata[7:0]),
        .i_frame_length (s_axis_tdata[23:8]),
        .i_timestamp    (s_axis_tdata[55:24]),
        .i_push_ready   (push_ready),
        .o_push         (push),
        .o_cmd          (front_cmd)
    );

    crcfpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (push_ready),
        .o_valid (head_valid),
        .o_cmd   (head_cmd),
        .i_pop   (pop)
    );

    crcfpb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (head_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_last      (m_axis_tuser[0]),
        .o_eof       (m_axis_tlast)
    );

endmodule

[dv/crcfpb_checker.sv]
// crcfpb_checker: watches both stream channels of the frame builder, predicts every output
// beat from the accepted input beats and compares them in order; depends on crcfpb_pkg
`timescale 1ns / 100ps

module crcfpb_checker import crcfpb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [55:0] i_s_tdata,   // payload_byte[7:0], frame_length[23:8], timestamp[55:24]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,   // frame_byte[7:0]
    input  logic        i_m_tlast,
    input  logic [0:0]  i_m_tuser,   // last_of_run[0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_frames_done,
    output int          o_bytes_checked
);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_of_run;
        logic       end_of_frame;
    } t_frame_beat;

    t_frame_beat expected_bytes[$];
    t_frame_beat tail;
    t_frame_beat want;
    logic [15:0] crc_acc;
    logic [15:0] payload_left;
    logic        in_frame;
    int          fail_count;
    int          frames_done;
    int          bytes_checked;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_frames_done   = 0;
        o_bytes_checked = 0;
        fail_count      = 0;
        frames_done     = 0;
        bytes_checked   = 0;
        crc_acc         = CRC_INIT;
        payload_left    = 16'h0000;
        in_frame        = 1'b0;
    end

    // msb-first crc, one data bit per step
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ b[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic feed, input logic eof);
        t_frame_beat nb;
        nb.frame_byte   = b;
        nb.last_of_run  = 1'b0;
        nb.end_of_frame = eof;
        expected_bytes.push_back(nb);
        if (feed) begin
            crc_acc = crc16_byte(crc_acc, b);
        end
    endtask

    task automatic close_frame();
        logic [15:0] c;
        c = crc_acc;
        add_byte(c[7:0], 1'b0, 1'b0);
        add_byte(c[15:8], 1'b0, 1'b1);
        crc_acc      = CRC_INIT;
        payload_left = 16'h0000;
        in_frame     = 1'b0;
    endtask

    task automatic predict_item(input logic [55:0] beat);
        logic [7:0]  pb;
        logic [15:0] len;
        logic [31:0] ts;
        pb  = beat[7:0];
        len = beat[23:8];
        ts  = beat[55:24];
        if (!in_frame) begin
            crc_acc = CRC_INIT;
            add_byte(SYNC_A, 1'b1, 1'b0);
            add_byte(SYNC_B, 1'b1, 1'b0);
            add_byte(SYNC_A, 1'b1, 1'b0);
            add_byte(SYNC_B, 1'b1, 1'b0);
            add_byte(len[7:0], 1'b1, 1'b0);
            add_byte(len[15:8], 1'b1, 1'b0);
            for (int k = 0; k < 4; k++) begin
                add_byte(ts[8*k +: 8], 1'b1, 1'b0);
            end
            if (len == 16'h0000) begin
                close_frame();
            end else begin
                add_byte(pb, 1'b1, 1'b0);
                payload_left = len - 16'h0001;
                in_frame     = 1'b1;
                if (payload_left == 16'h0000) begin
                    close_frame();
                end
            end
        end else begin
            add_byte(pb, 1'b1, 1'b0);
            if (payload_left != 16'h0000) begin
                payload_left = payload_left - 16'h0001;
            end
            if (payload_left == 16'h0000) begin
                close_frame();
            end
        end
        tail = expected_bytes.pop_back();
        tail.last_of_run = 1'b1;
        expected_bytes.push_back(tail);
    endtask

    task automatic check_beat();
        if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected beat, nothing expected: actual byte %h last_of_run %b eof %b",
                     $time, i_m_tdata, i_m_tuser[0], i_m_tlast);
            fail_count++;
        end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (want.end_of_frame) begin
                frames_done++;
            end
            if (i_m_tdata !== want.frame_byte) begin
                $display("%0t: frame_byte mismatch: expected %h actual %h",
                         $time, want.frame_byte, i_m_tdata);
                fail_count++;
            end
            if (i_m_tuser[0] !== want.last_of_run) begin
                $display("%0t: last_of_run mismatch: expected %b actual %b",
                         $time, want.last_of_run, i_m_tuser[0]);
                fail_count++;
            end
            if (i_m_tlast !== want.end_of_frame) begin
                $display("%0t: end_of_frame mismatch: expected %b actual %b",
                         $time, want.end_of_frame, i_m_tlast);
                fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bytes.delete();
            crc_acc      = CRC_INIT;
            payload_left = 16'h0000;
            in_frame     = 1'b0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_beat();
            end
            if (i_s_tvalid && i_s_tready) begin
                predict_item(i_s_tdata);
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= expected_bytes.size();
        o_frames_done   <= frames_done;
        o_bytes_checked <= bytes_checked;
    end

endmodule

[dv/tb.sv]
// tb: stimulus and verdict for crc16_framed_packet_builder; the checker predicts and compares
// depends on crcfpb_pkg, crc16_framed_packet_builder, crcfpb_checker
`timescale 1ns / 100ps

module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // payload_byte[7:0], frame_length[23:8], timestamp[55:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // frame_byte[7:0]
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;        // last_of_run[0]

    int snd_idle_pct = 20;
    int rcv_idle_pct = 57;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int items_sent = 0;
    int fail_count;
    int pending;
    int frames_done;
    int bytes_checked;

    crc16_framed_packet_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    crcfpb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tlast       (m_axis_tlast),
        .i_m_tuser       (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_frames_done   (frames_done),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // receiver: random backpressure, plus a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= 300;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_item(input logic [7:0] pb, input logic [15:0] len, input logic [31:0] ts);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ts, len, pb};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // payload beats carry junk in the length and timestamp fields, which must be ignored
    task automatic send_frame(input logic [15:0] len);
        send_item(8'($urandom_range(255)), len, $urandom);
        for (int i = 1; i < len; i++) begin
            send_item(8'($urandom_range(255)), 16'($urandom_range(65535)), $urandom);
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [15:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            return 16'd0;
        end else if (r < 24) begin
            return 16'd1;
        end else if (r < 88) begin
            return 16'($urandom_range(8, 2));
        end
        return 16'($urandom_range(40, 9));
    endfunction

    task automatic random_frames(input int n_items);
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            send_frame(pick_length());
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length frames, length-one frames, short frames with junk in ignored fields
        send_item(8'hFF, 16'h0000, 32'h0000_0000);
        send_item(8'h00, 16'h0000, 32'hFFFF_FFFF);
        send_item(8'h00, 16'h0001, 32'h1234_5678);
        send_item(8'hFF, 16'h0001, 32'hFFFF_FFFF);
        send_item(8'hA5, 16'h0003, 32'h8000_0001);
        send_item(8'h00, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(8'hFF, 16'h0000, 32'h0000_0000);
        send_item(8'h5A, 16'h0002, 32'h0000_0000);
        send_item(8'h80, 16'h1234, 32'hDEAD_BEEF);
        wait_drained();

        random_frames(130);
        wait_drained();

        snd_idle_pct = 57;
        rcv_idle_pct <= 20;
        random_frames(130);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        // long output stall while input keeps coming, so the block backs up
        hold_req <= hold_req + 1;
        send_frame(16'd40);
        wait_drained();
        random_frames(130);
        wait_drained();

        repeat (20) @(posedge i_clk);
        $display("run covered %0d input beats, %0d frames closed, %0d frame bytes compared",
                 items_sent, frames_done, bytes_checked);
        $display("idle mixes 20/57, 57/20 and none, a 300-cycle output stall, frames of 0 to 40");
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            if (pending != 0) begin
                $display("%0d expected frame bytes never arrived", pending);
            end
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout with %0d frame bytes outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[crc16_framed_packet_builder.f]
rtl/crcfpb_pkg.sv
rtl/crcfpb_front.sv
rtl/crcfpb_queue.sv
rtl/crcfpb_back.sv
rtl/crc16_framed_packet_builder.sv
dv/crcfpb_checker.sv
dv/tb.sv
